### src/rsmp_pkg.sv
// Shared types and constants of the polyline arc-length resampler.
`timescale 1ns / 1ps
`default_nettype none
package rsmp_pkg;

   localparam int CW          = 32;   // coordinate width
   localparam int DW          = 33;   // coordinate difference width
   localparam int ROOT_W      = 34;   // segment length width
   localparam int ACC_W       = 67;   // product accumulator width
   localparam int NUM_W       = 68;   // iterative unit numerator shift register
   localparam int REM_W       = 37;   // iterative unit partial remainder
   localparam int CNT_W       = 6;
   localparam int K_W         = 6;
   localparam int MAX_SAMPLES = 64;
   localparam int SQRT_STEPS  = 34;
   localparam int NDIV_STEPS  = 34;
   localparam int IDIV_STEPS  = 33;
   localparam logic [CW-1:0] RESET_STEP = 32'h0001_0000;

   typedef struct packed {
      logic signed [CW-1:0] x_in;
      logic signed [CW-1:0] y_in;
      logic signed [CW-1:0] z_in;
      logic                 first_vertex;
   } req_type;

   typedef struct packed {
      logic signed [CW-1:0] x_out;
      logic signed [CW-1:0] y_out;
      logic signed [CW-1:0] z_out;
      logic                 last;
      logic                 dropped;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic hi;
   } mul_ctl_type;

   typedef struct packed {
      logic load;
      logic step;
      logic sqrt;
   } iter_ctl_type;

   typedef enum logic [9:0] {
      ST_IDLE = 10'b00_0000_0001,
      ST_SQR  = 10'b00_0000_0010,
      ST_ROOT = 10'b00_0000_0100,
      ST_CHK  = 10'b00_0000_1000,
      ST_NDIV = 10'b00_0001_0000,
      ST_PLAN = 10'b00_0010_0000,
      ST_MUL  = 10'b00_0100_0000,
      ST_DIV  = 10'b00_1000_0000,
      ST_ADD  = 10'b01_0000_0000,
      ST_OUT  = 10'b10_0000_0000
   } state_type;

endpackage
`default_nettype wire

### src/polyline_arc_length_resampler_top.sv
// Top level of the polyline arc-length resampler: sequencer, state and ports.
// A first vertex (or any vertex before one was seen) is only stored as the start
// point. Every other vertex finds its segment length by a multiply, a square root
// and a check; when at least one sample lands in it, it then divides to count its
// samples. Each sample is built in the single iterative divide unit: a multiply, a
// divide and an add for each of x, y and z, then an output state in which the sample
// waits until it is taken. The block takes no request while a vertex is in work.
// The step register may be written at any time the block is idle; csr_ready is
// always high.
`timescale 1ns / 1ps
`default_nettype none
module polyline_arc_length_resampler_top import rsmp_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_stall,
   input  wire req_type       req_data,
   output      logic          rsp_valid,
   input  wire logic          rsp_stall,
   output      rsp_type       rsp_data,
   input  wire logic          csr_valid,
   output      logic          csr_ready,
   input  wire logic [CW-1:0] csr_data
);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [1:0]         coord_ff, coord_in;
   logic               have_prev_ff, have_prev_in;
   logic [CW-1:0]      off_ff, off_in;
   logic [CW-1:0]      step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [K_W-1:0]     k_ff, k_in, klast_ff, klast_in;

   logic signed [CW-1:0] prev_x_ff, prev_y_ff, prev_z_ff, prev_x_in, prev_y_in, prev_z_in;
   logic signed [CW-1:0] vtx_x_ff, vtx_y_ff, vtx_z_ff, vtx_x_in, vtx_y_in, vtx_z_in;
   logic signed [DW-1:0] dx_ff, dy_ff, dz_ff, dx_in, dy_in, dz_in;
   logic [CW-1:0]        newoff_ff, newoff_in;
   logic [ROOT_W-1:0]    ri_ff, ri_in, p_ff, p_in;
   logic                 drop_ff, drop_in;
   rsp_type              rsp_ff, rsp_in;

   mul_ctl_type        mctl;
   iter_ctl_type       ictl;
   logic [DW-1:0]      mul_a;
   logic [ROOT_W-1:0]  mul_b;
   logic [ACC_W-1:0]   acc;
   logic [REM_W-1:0]   load_rem, irem;
   logic [NUM_W-1:0]   load_num;
   logic [ROOT_W-1:0]  divisor, iquo, ri_left;
   logic signed [DW-1:0] d_sel;
   logic signed [CW-1:0] base_sel;
   logic [DW-1:0]      mag_x, mag_y, mag_sel;
   logic [DW-1:0]      sum;
   logic               req_acc, finish;

   rsmp_mul u_mul (
      .clock (clock),
      .ctl   (mctl),
      .a     (mul_a),
      .b     (mul_b),
      .acc   (acc)
   );

   rsmp_iter u_iter (
      .clock    (clock),
      .ctl      (ictl),
      .load_rem (load_rem),
      .load_num (load_num),
      .divisor  (divisor),
      .quo      (iquo),
      .rem      (irem)
   );

   always_comb begin
      case (coord_ff)
         2'd0: begin
            d_sel    = dx_ff;
            base_sel = prev_x_ff;
         end
         2'd1: begin
            d_sel    = dy_ff;
            base_sel = prev_y_ff;
         end
         default: begin
            d_sel    = dz_ff;
            base_sel = prev_z_ff;
         end
      endcase
      mag_x   = dx_ff[DW-1] ? DW'(0) - dx_ff : dx_ff;
      mag_y   = dy_ff[DW-1] ? DW'(0) - dy_ff : dy_ff;
      mag_sel = d_sel[DW-1] ? DW'(0) - d_sel : d_sel;
      ri_left = ri_ff - {2'b00, off_ff};
      sum     = d_sel[DW-1] ? {base_sel[CW-1], base_sel} - iquo[DW-1:0]
                            : {base_sel[CW-1], base_sel} + iquo[DW-1:0];
   end

   // Shared unit steering
   always_comb begin
      mctl.clear = (cnt_ff == '0);
      mctl.hi    = cnt_ff[0];
      if (state_ff == ST_SQR) begin
         mul_a = cnt_ff[1] ? mag_y : mag_x;
         mul_b = {1'b0, mul_a};
      end else begin
         mul_a = mag_sel;
         mul_b = p_ff;
      end
      ictl.load = (cnt_ff == '0);
      ictl.step = (cnt_ff != '0);
      ictl.sqrt = (state_ff == ST_ROOT);
      divisor   = (state_ff == ST_NDIV) ? {2'b00, step_ff} : ri_ff;
      case (state_ff)
         ST_ROOT: begin
            load_rem = '0;
            load_num = {1'b0, acc};
         end
         ST_NDIV: begin
            load_rem = '0;
            load_num = {ri_left, {ROOT_W{1'b0}}};
         end
         default: begin
            load_rem = {3'b000, acc[ACC_W-1:DW]};
            load_num = {acc[DW-1:0], {(NUM_W-DW){1'b0}}};
         end
      endcase
   end

   assign req_acc   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff + CNT_W'(1);
      coord_in     = coord_ff;
      have_prev_in = have_prev_ff;
      off_in       = off_ff;
      step_in      = (csr_valid && csr_ready) ? csr_data : step_ff;
      rsp_valid_in = rsp_valid_ff;
      k_in         = k_ff;
      klast_in     = klast_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      prev_z_in    = prev_z_ff;
      vtx_x_in     = vtx_x_ff;
      vtx_y_in     = vtx_y_ff;
      vtx_z_in     = vtx_z_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      dz_in        = dz_ff;
      newoff_in    = newoff_ff;
      ri_in        = ri_ff;
      p_in         = p_ff;
      drop_in      = drop_ff;
      rsp_in       = rsp_ff;
      finish       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_acc) begin
               if (req_data.first_vertex || !have_prev_ff) begin
                  prev_x_in    = req_data.x_in;
                  prev_y_in    = req_data.y_in;
                  prev_z_in    = req_data.z_in;
                  have_prev_in = 1'b1;
                  off_in       = '0;
               end else begin
                  vtx_x_in = req_data.x_in;
                  vtx_y_in = req_data.y_in;
                  vtx_z_in = req_data.z_in;
                  dx_in    = DW'(req_data.x_in) - DW'(prev_x_ff);
                  dy_in    = DW'(req_data.y_in) - DW'(prev_y_ff);
                  dz_in    = DW'(req_data.z_in) - DW'(prev_z_ff);
                  state_in = ST_SQR;
               end
            end
         end
         ST_SQR: begin
            if (cnt_ff == CNT_W'(3)) begin
               cnt_in   = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (cnt_ff == CNT_W'(SQRT_STEPS)) begin
               cnt_in   = '0;
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            cnt_in = '0;
            ri_in  = iquo;
            if (iquo == '0) begin
               finish = 1'b1;
            end else if (step_ff == '0) begin
               off_in = '0;
               finish = 1'b1;
            end else if ({2'b00, off_ff} <= iquo) begin
               state_in = ST_NDIV;
            end else begin
               // no grid point in this segment: carry the distance left
               off_in = off_ff - iquo[CW-1:0];
               finish = 1'b1;
            end
         end
         ST_NDIV: begin
            if (cnt_ff == CNT_W'(NDIV_STEPS)) begin
               cnt_in   = '0;
               state_in = ST_PLAN;
            end
         end
         ST_PLAN: begin
            cnt_in    = '0;
            drop_in   = (iquo >= ROOT_W'(MAX_SAMPLES));
            klast_in  = drop_in ? K_W'(MAX_SAMPLES - 1) : iquo[K_W-1:0];
            newoff_in = step_ff - irem[CW-1:0];
            p_in      = {2'b00, off_ff};
            k_in      = '0;
            coord_in  = '0;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            if (cnt_ff == CNT_W'(1)) begin
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (cnt_ff == CNT_W'(IDIV_STEPS)) begin
               cnt_in   = '0;
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cnt_in = '0;
            case (coord_ff)
               2'd0:    rsp_in.x_out = sum[CW-1:0];
               2'd1:    rsp_in.y_out = sum[CW-1:0];
               default: rsp_in.z_out = sum[CW-1:0];
            endcase
            if (coord_ff == 2'd2) begin
               rsp_in.last    = (k_ff == klast_ff);
               rsp_in.dropped = drop_ff;
               rsp_valid_in   = 1'b1;
               state_in       = ST_OUT;
            end else begin
               coord_in = coord_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_OUT: begin
            cnt_in = '0;
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (k_ff == klast_ff) begin
                  off_in = newoff_ff;
                  finish = 1'b1;
               end else begin
                  k_in     = k_ff + K_W'(1);
                  p_in     = p_ff + {2'b00, step_ff};
                  coord_in = '0;
                  state_in = ST_MUL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         prev_x_in = vtx_x_ff;
         prev_y_in = vtx_y_ff;
         prev_z_in = vtx_z_ff;
         state_in  = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         coord_ff     <= '0;
         have_prev_ff <= 1'b0;
         off_ff       <= '0;
         step_ff      <= RESET_STEP;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         klast_ff     <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_z_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         coord_ff     <= coord_in;
         have_prev_ff <= have_prev_in;
         off_ff       <= off_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         klast_ff     <= klast_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         prev_z_ff    <= prev_z_in;
      end
   end

   always_ff @(posedge clock) begin
      vtx_x_ff  <= vtx_x_in;
      vtx_y_ff  <= vtx_y_in;
      vtx_z_ff  <= vtx_z_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      dz_ff     <= dz_in;
      newoff_ff <= newoff_in;
      ri_ff     <= ri_in;
      p_ff      <= p_in;
      drop_ff   <= drop_in;
      rsp_ff    <= rsp_in;
   end

endmodule
`default_nettype wire

### src/rsmp_mul.sv
// Shared multiply-accumulate unit: 33 x 17 partial products into a 67-bit accumulator.
`timescale 1ns / 1ps
`default_nettype none
module rsmp_mul import rsmp_pkg::*; (
   input  wire logic              clock,
   input  wire mul_ctl_type       ctl,
   input  wire logic [DW-1:0]     a,
   input  wire logic [ROOT_W-1:0] b,
   output      logic [ACC_W-1:0]  acc
);

   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [16:0]      b_part;
   logic [49:0]      pp;
   logic [ACC_W-1:0] pp_sh;

   always_comb begin
      b_part = ctl.hi ? b[33:17] : b[16:0];
      pp     = a * b_part;
      pp_sh  = ctl.hi ? {pp, 17'b0} : {17'b0, pp};
      acc_in = (ctl.clear ? '0 : acc_ff) + pp_sh;
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule
`default_nettype wire

### src/rsmp_iter.sv
// Shared restoring unit: one square-root digit or one quotient bit per cycle while stepping.
`timescale 1ns / 1ps
`default_nettype none
module rsmp_iter import rsmp_pkg::*; (
   input  wire logic              clock,
   input  wire iter_ctl_type      ctl,
   input  wire logic [REM_W-1:0]  load_rem,
   input  wire logic [NUM_W-1:0]  load_num,
   input  wire logic [ROOT_W-1:0] divisor,
   output      logic [ROOT_W-1:0] quo,
   output      logic [REM_W-1:0]  rem
);

   logic [REM_W-1:0]  rem_ff, rem_in, rem_sh, trial;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [ROOT_W-1:0] quo_ff, quo_in;
   logic [REM_W:0]    diff;

   always_comb begin
      if (ctl.sqrt) begin
         rem_sh = {rem_ff[REM_W-3:0], num_ff[NUM_W-1 -: 2]};
         trial  = {1'b0, quo_ff, 2'b01};
      end else begin
         rem_sh = {rem_ff[REM_W-2:0], num_ff[NUM_W-1]};
         trial  = {3'b0, divisor};
      end
      diff   = {1'b0, rem_sh} - {1'b0, trial};
      rem_in = rem_ff;
      num_in = num_ff;
      quo_in = quo_ff;
      if (ctl.load) begin
         rem_in = load_rem;
         num_in = load_num;
         quo_in = '0;
      end else if (ctl.step) begin
         num_in = ctl.sqrt ? {num_ff[NUM_W-3:0], 2'b00} : {num_ff[NUM_W-2:0], 1'b0};
         if (!diff[REM_W]) begin
            rem_in = diff[REM_W-1:0];
            quo_in = {quo_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign quo = quo_ff;
   assign rem = rem_ff;

endmodule
`default_nettype wire

### src/rsmp_checker.sv
// Port-level checks for the resampler top level, bound to it.
`timescale 1ns / 1ps
`default_nettype none
module rsmp_checker import rsmp_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // a stalled result holds its valid and data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // no new vertex while a sample waits
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request side open while result pending");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a sample only appears after the block has been busy
   a_out_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without work");

endmodule

bind polyline_arc_length_resampler_top rsmp_checker u_rsmp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
